// ===== hw/rtl/cpvp_pkg.sv =====
// Package: types, constants and saturation helpers for the servo controller.
`timescale 1ns / 1ps
package cpvp_pkg;

  localparam int unsigned COMMAND_SCALE = 65536;
  localparam int SCALE_W = $clog2(COMMAND_SCALE) + 1;
  localparam logic [SCALE_W-1:0] SCALE_C = SCALE_W'(COMMAND_SCALE);
  localparam int ERR_W = 16 + SCALE_W + 2;

  localparam int ADDR_W = 5;
  localparam int REG_W  = 31;
  localparam int DATA_W = 32;
  localparam int IN_W   = 136;
  localparam int OUT_W  = 160;

  typedef enum logic [2:0] {
    REG_POS_GAIN,
    REG_VEL_GAIN,
    REG_INT_GAIN,
    REG_INERTIA,
    REG_DEADBAND,
    REG_VEL_LIMIT,
    REG_ACC_LIMIT,
    REG_TRQ_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] position_gain;
    logic [REG_W-1:0] velocity_gain;
    logic [REG_W-1:0] integral_gain;
    logic [REG_W-1:0] inertia;
    logic [REG_W-1:0] deadband;
    logic [REG_W-1:0] velocity_limit;
    logic [REG_W-1:0] accel_limit;
    logic [REG_W-1:0] torque_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_P,
    ST_VEL,
    ST_MUL_V,
    ST_ACC,
    ST_MUL_T,
    ST_TRQ,
    ST_MUL_I,
    ST_INT,
    ST_FIN
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

  // symmetric clamp to +/- lim
  function automatic logic signed [31:0] clamp31(input logic signed [31:0] v,
                                                 input logic [REG_W-1:0] lim);
    logic signed [32:0] v33;
    logic signed [32:0] l33;
    logic signed [32:0] r;
    v33 = 33'(v);
    l33 = $signed({2'b00, lim});
    if (v33 > l33) begin
      r = l33;
    end else if (v33 < -l33) begin
      r = -l33;
    end else begin
      r = v33;
    end
    return $signed(r[31:0]);
  endfunction

endpackage

// ===== hw/rtl/cpvp_regs.sv =====
// APB register file for the servo gains and limits.
`timescale 1ns / 1ps
module cpvp_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cpvp_pkg::ADDR_W-1:0] paddr,
  input  logic [cpvp_pkg::DATA_W-1:0] pwdata,
  output logic [cpvp_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output cpvp_pkg::cfg_t             cfg
);
  import cpvp_pkg::*;

  reg_idx_t idx;
  logic     wr;
  logic [REG_W-1:0] wval;
  logic [REG_W-1:0] rval;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign wval   = pwdata[REG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_POS_GAIN:  cfg.position_gain  <= wval;
        REG_VEL_GAIN:  cfg.velocity_gain  <= wval;
        REG_INT_GAIN:  cfg.integral_gain  <= wval;
        REG_INERTIA:   cfg.inertia        <= wval;
        REG_DEADBAND:  cfg.deadband       <= wval;
        REG_VEL_LIMIT: cfg.velocity_limit <= wval;
        REG_ACC_LIMIT: cfg.accel_limit    <= wval;
        REG_TRQ_LIMIT: cfg.torque_limit   <= wval;
        default:       cfg.torque_limit   <= cfg.torque_limit;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_POS_GAIN:  rval = cfg.position_gain;
      REG_VEL_GAIN:  rval = cfg.velocity_gain;
      REG_INT_GAIN:  rval = cfg.integral_gain;
      REG_INERTIA:   rval = cfg.inertia;
      REG_DEADBAND:  rval = cfg.deadband;
      REG_VEL_LIMIT: rval = cfg.velocity_limit;
      REG_ACC_LIMIT: rval = cfg.accel_limit;
      REG_TRQ_LIMIT: rval = cfg.torque_limit;
      default:       rval = '0;
    endcase
  end

  assign prdata = {1'b0, rval};

endmodule

// ===== hw/rtl/cpvp_mul.sv =====
// Shared Q16.16 multiplier: registered product, floor shift and saturation.
`timescale 1ns / 1ps
module cpvp_mul (
  input  logic                       clk,
  input  logic                       load,
  input  logic signed [31:0]         a,
  input  logic [cpvp_pkg::REG_W-1:0] gain,
  output logic signed [31:0]         q
);
  import cpvp_pkg::*;

  logic signed [31:0] g_s;
  logic signed [63:0] prod;

  assign g_s = $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= a * g_s;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign q = sat32(prod >>> 16);

endmodule

// ===== hw/rtl/cascaded_position_velocity_pi.sv =====
// Top level: cascaded position/velocity PI servo controller with sequencer.
// Sequence: ST_ERR, then for an enabled item ST_MUL_P, ST_VEL, ST_MUL_V,
//   ST_ACC, ST_MUL_T, ST_TRQ, ST_MUL_I and ST_INT, then ST_FIN; the one shared
//   32x32 multiplier is used for four dependent products in turn. ST_FIN waits
//   for a free output and registers the result; ready returns the cycle after.
// Reset: synchronous, clears registers, kept angles, error and integrator.
`timescale 1ns / 1ps
module cascaded_position_velocity_pi (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // position_command, position_feedback, velocity_feedforward,
  // velocity_feedback, torque_feedforward, enable, zero pad
  input  logic [cpvp_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // torque_command, velocity_command, position_error_out,
  // velocity_error, acceleration_command
  output logic [cpvp_pkg::OUT_W-1:0]  m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpvp_pkg::ADDR_W-1:0] paddr,
  input  logic [cpvp_pkg::DATA_W-1:0] pwdata,
  output logic [cpvp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import cpvp_pkg::*;

  cfg_t   cfg;
  state_t state, state_next;

  logic [15:0]        cmd_in, fb_in, last_cmd, last_fb;
  logic signed [31:0] vff, vfb, tff;
  logic               en_r;
  logic signed [31:0] pos_err, integ, vcmd, verr, acc, tp;

  logic               mul_load;
  logic signed [31:0] mul_a;
  logic [REG_W-1:0]   mul_g;
  logic signed [31:0] mq;
  logic               out_free, fin_fire;

  logic [15:0]             dc_u, df_u;
  logic signed [ERR_W-1:0] e_sum;
  logic signed [31:0]      perr_new, vp, vcmd_new, verr_new, isum, integ_new, tcmd;
  logic signed [32:0]      mag;
  logic signed [33:0]      tl34, lo, hi, ic;

  cpvp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpvp_mul u_mul (
    .clk  (clk),
    .load (mul_load),
    .a    (mul_a),
    .gain (mul_g),
    .q    (mq)
  );

  assign out_free = !m_tvalid || m_tready;

  // datapath arithmetic
  always_comb begin
    dc_u  = cmd_in - last_cmd;
    df_u  = fb_in - last_fb;
    e_sum = ERR_W'(pos_err)
          + ERR_W'($signed(dc_u)) * ERR_W'($signed({1'b0, SCALE_C}))
          - ERR_W'($signed(df_u));
    perr_new = sat32(64'(e_sum));

    vp  = clamp31(mq, cfg.velocity_limit);
    mag = (pos_err < 0) ? -33'(pos_err) : 33'(pos_err);
    if (mag < $signed({2'b00, cfg.deadband})) begin
      vp = '0;
    end
    vcmd_new = sat32(64'(vp) + 64'(vff));
    verr_new = sat32(64'(vcmd_new) - 64'(vfb));

    isum = sat32(64'(integ) + 64'(mq));
    tl34 = $signed({3'b000, cfg.torque_limit});
    lo   = -tl34 - 34'(tp);
    hi   = tl34 - 34'(tp);
    ic   = 34'(isum);
    if (ic < lo) begin
      ic = lo;
    end
    if (ic > hi) begin
      ic = hi;
    end
    integ_new = sat32(64'(ic));

    tcmd = sat32(64'(tp) + 64'(tff) + 64'(integ));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_ERR;
      ST_ERR:   state_next = en_r ? ST_MUL_P : ST_FIN;
      ST_MUL_P: state_next = ST_VEL;
      ST_VEL:   state_next = ST_MUL_V;
      ST_MUL_V: state_next = ST_ACC;
      ST_ACC:   state_next = ST_MUL_T;
      ST_MUL_T: state_next = ST_TRQ;
      ST_TRQ:   state_next = ST_MUL_I;
      ST_MUL_I: state_next = ST_INT;
      ST_INT:   state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    mul_load = 1'b0;
    mul_a    = pos_err;
    mul_g    = cfg.position_gain;
    fin_fire = 1'b0;
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_MUL_P: mul_load = 1'b1;
      ST_MUL_V: begin
        mul_load = 1'b1;
        mul_a    = verr;
        mul_g    = cfg.velocity_gain;
      end
      ST_MUL_T: begin
        mul_load = 1'b1;
        mul_a    = acc;
        mul_g    = cfg.inertia;
      end
      ST_MUL_I: begin
        mul_load = 1'b1;
        mul_a    = verr;
        mul_g    = cfg.integral_gain;
      end
      ST_FIN:   fin_fire = out_free;
      default:  mul_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      last_cmd <= '0;
      last_fb  <= '0;
      pos_err  <= '0;
      integ    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_ERR: begin
          last_cmd <= cmd_in;
          last_fb  <= fb_in;
          if (en_r) begin
            pos_err <= perr_new;
          end else begin
            pos_err <= '0;
            integ   <= '0;
          end
        end
        ST_INT:  integ <= integ_new;
        default: pos_err <= pos_err;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_in <= s_tdata[15:0];
      fb_in  <= s_tdata[31:16];
      vff    <= $signed(s_tdata[63:32]);
      vfb    <= $signed(s_tdata[95:64]);
      tff    <= $signed(s_tdata[127:96]);
      en_r   <= s_tdata[128];
    end
    if (state == ST_VEL) begin
      vcmd <= vcmd_new;
      verr <= verr_new;
    end
    if (state == ST_ACC) begin
      acc <= clamp31(mq, cfg.accel_limit);
    end
    if (state == ST_TRQ) begin
      tp <= clamp31(mq, cfg.torque_limit);
    end
    if (fin_fire) begin
      m_tdata <= en_r ? {acc, verr, pos_err, vcmd, tcmd} : '0;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("accepted a new item while busy");

  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    (fin_fire && !en_r) |=> (m_tdata == '0))
    else $error("disabled item gave nonzero result");

  a_integ_headroom: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && en_r) |->
      ((34'(tp) + 34'(integ) <= tl34) && (34'(tp) + 34'(integ) >= -tl34)))
    else $error("integrator exceeds torque headroom");

  a_acc_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_T) |->
      ((33'(acc) <= $signed({2'b00, cfg.accel_limit}))
       && (33'(acc) >= -$signed({2'b00, cfg.accel_limit}))))
    else $error("acceleration outside limit");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking stream testbench for the cascaded position/velocity PI servo controller.
`timescale 1ns / 1ps
module testbench;
  import cpvp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 6;
  localparam int TICKS_PER_PHASE = 88;

  // one servo tick, packed so that position_command sits in the lowest bits
  typedef struct packed {
    logic               en;
    logic signed [31:0] tff;
    logic signed [31:0] vfb;
    logic signed [31:0] vff;
    logic [15:0]        pf;
    logic [15:0]        pc;
  } servo_tick_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  cascaded_position_velocity_pi dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  servo_tick_t      tick_q[$];
  servo_tick_t      tick_on_bus;
  logic [OUT_W-1:0] servo_out_q[$];
  logic [OUT_W-1:0] want_out;
  logic [30:0]      cfg_shadow [8];
  logic [15:0]      prev_cmd_angle = '0;
  logic [15:0]      prev_fb_angle = '0;
  longint           err_acc = 0;
  longint           integ_acc = 0;
  logic [15:0]      gen_cmd_angle = '0;
  logic [15:0]      gen_fb_angle = '0;
  bit               idle_on = 1'b1;
  bit               s_took = 1'b0;
  int               s_gap = 0;
  int               m_hold = 0;
  int               m_long_hold = 0;
  int               quiet_cycles = 0;
  int               mismatches = 0;
  int               n_ticks = 0;
  int               n_disabled = 0;
  int               n_results = 0;
  int               n_writes = 0;
  int               n_settings = 0;
  string            out_field [5] = '{"torque_command", "velocity_command",
                                      "position_error_out", "velocity_error",
                                      "acceleration_command"};

  initial begin
    for (int i = 0; i < 8; i++) cfg_shadow[i] = '0;
  end

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact product, floor divide by 2^16, saturate
  function automatic longint mul_q16(longint a, logic [30:0] g);
    longint gl;
    gl = longint'({33'd0, g});
    return sat_q((a * gl) >>> 16);
  endfunction

  function automatic longint clip(longint v, logic [30:0] lim);
    longint l;
    l = longint'({33'd0, lim});
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic longint angle_step(logic [15:0] now, logic [15:0] old);
    logic signed [15:0] d;
    d = now - old;
    return longint'(d);
  endfunction

  function automatic logic [OUT_W-1:0] servo_tick(servo_tick_t t);
    longint perr, vcmd, verr, acc, trq, integ, lo, hi, lim, mag;
    perr = 0;
    vcmd = 0;
    verr = 0;
    acc  = 0;
    trq  = 0;
    if (t.en) begin
      perr = sat_q(err_acc + angle_step(t.pc, prev_cmd_angle) * longint'(COMMAND_SCALE)
                   - angle_step(t.pf, prev_fb_angle));
      err_acc = perr;
      vcmd = clip(mul_q16(perr, cfg_shadow[REG_POS_GAIN]), cfg_shadow[REG_VEL_LIMIT]);
      mag = (perr < 0) ? -perr : perr;
      if (mag < longint'({33'd0, cfg_shadow[REG_DEADBAND]})) vcmd = 0;
      vcmd = sat_q(vcmd + longint'(t.vff));
      verr = sat_q(vcmd - longint'(t.vfb));
      acc  = clip(mul_q16(verr, cfg_shadow[REG_VEL_GAIN]), cfg_shadow[REG_ACC_LIMIT]);
      trq  = clip(mul_q16(acc, cfg_shadow[REG_INERTIA]), cfg_shadow[REG_TRQ_LIMIT]);
      lim  = longint'({33'd0, cfg_shadow[REG_TRQ_LIMIT]});
      integ = sat_q(integ_acc + mul_q16(verr, cfg_shadow[REG_INT_GAIN]));
      lo = -lim - trq;
      hi = lim - trq;
      if (integ < lo) integ = lo;
      if (integ > hi) integ = hi;
      integ = sat_q(integ);
      integ_acc = integ;
      trq = sat_q(trq + longint'(t.tff) + integ);
    end else begin
      err_acc = 0;
      integ_acc = 0;
    end
    prev_cmd_angle = t.pc;
    prev_fb_angle  = t.pf;
    return {acc[31:0], verr[31:0], perr[31:0], vcmd[31:0], trq[31:0]};
  endfunction

  function automatic void push_tick(logic [15:0] dc, logic [15:0] dp, logic signed [31:0] vff,
                                    logic signed [31:0] vfb, logic signed [31:0] tff,
                                    logic en);
    servo_tick_t t;
    gen_cmd_angle = gen_cmd_angle + dc;
    gen_fb_angle  = gen_fb_angle + dp;
    t.pc  = gen_cmd_angle;
    t.pf  = gen_fb_angle;
    t.vff = vff;
    t.vfb = vfb;
    t.tff = tff;
    t.en  = en;
    tick_q.push_back(t);
  endfunction

  function automatic logic signed [31:0] rand_s32();
    case ($urandom_range(0, 6))
      0:       return 32'sd0;
      1:       return 32'sh7FFFFFFF;
      2:       return 32'sh80000000;
      3, 4:    return $urandom_range(0, 2097152) - 32'd1048576;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] angle_extreme();
    case ($urandom_range(0, 3))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h8001;
      default: return 16'hFFFF;
    endcase
  endfunction

  // command mostly holds still so the error stays out of saturation
  function automatic logic [15:0] rand_cmd_step();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'd0;
      5, 6:          return 16'($urandom_range(0, 6) - 3);
      7:             return 16'($urandom_range(0, 600) - 300);
      8:             return angle_extreme();
      default:       return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_fb_step();
    case ($urandom_range(0, 5))
      0, 1, 2: return 16'($urandom_range(0, 1024) - 512);
      3:       return 16'($urandom_range(0, 40000) - 20000);
      4:       return angle_extreme();
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] rand_cfg();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return 31'($urandom_range(1, 255));
      3:       return 31'($urandom);
      4:       return 31'($urandom_range(32'h1000, 32'h40000));
      5:       return 31'($urandom_range(0, 32'h00FFFFFF));
      default: return 31'($urandom_range(32'h01000000, 32'h7FFFFFFF));
    endcase
  endfunction

  function automatic void push_random_tick();
    push_tick(rand_cmd_step(), rand_fb_step(), rand_s32(), rand_s32(), rand_s32(),
              $urandom_range(0, 11) != 0);
  endfunction

  // bit 31 of the write data is random; the register keeps 31 bits
  task automatic cfg_write(reg_idx_t r, logic [30:0] v);
    bit top;
    top = 1'($urandom_range(0, 1));
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(r));
    pwdata  <= {top, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cfg_shadow[r] = v;
    n_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_cfg(logic [30:0] pg, logic [30:0] vg, logic [30:0] ig, logic [30:0] inr,
                         logic [30:0] db, logic [30:0] vl, logic [30:0] al, logic [30:0] tl);
    cfg_write(REG_POS_GAIN, pg);
    cfg_write(REG_VEL_GAIN, vg);
    cfg_write(REG_INT_GAIN, ig);
    cfg_write(REG_INERTIA, inr);
    cfg_write(REG_DEADBAND, db);
    cfg_write(REG_VEL_LIMIT, vl);
    cfg_write(REG_ACC_LIMIT, al);
    cfg_write(REG_TRQ_LIMIT, tl);
    n_settings++;
  endtask

  task automatic wait_quiet();
    do @(posedge clk); while (tick_q.size() != 0 || s_tvalid || servo_out_q.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_took || !s_tvalid) begin
      s_took = 1'b0;
      if (s_gap > 0) begin
        s_gap--;
        s_tvalid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        tick_on_bus = tick_q.pop_front();
        s_tdata  <= IN_W'(tick_on_bus);
        s_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) s_gap = $urandom_range(1, 18);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_long_hold > 0) begin
      m_long_hold--;
      m_tready <= 1'b0;
    end else if (m_hold > 0) begin
      m_hold--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_hold = $urandom_range(0, 17);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // transaction monitor and checker
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      servo_out_q.push_back(servo_tick(tick_on_bus));
      s_took = 1'b1;
      n_ticks++;
      if (!tick_on_bus.en) n_disabled++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (servo_out_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want_out = servo_out_q.pop_front();
        n_results++;
        for (int k = 0; k < 5; k++) begin
          if (m_tdata[32*k +: 32] !== want_out[32*k +: 32]) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, out_field[k],
                     $signed(want_out[32*k +: 32]), $signed(m_tdata[32*k +: 32]));
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("cascaded_position_velocity_pi verification failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers still at reset: all gains and limits zero
    push_tick(16'd5, 16'd3, 32'sd1000, -32'sd77, 32'sh7FFFFFFF, 1'b1);
    push_tick(16'hFFFF, 16'hFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
    push_tick(16'h1234, 16'h4321, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    wait_quiet();

    set_cfg(31'h10000, 31'h8000, 31'h800, 31'h20000, 31'd100, 31'h100000, 31'h200000,
            31'h400000);
    push_tick(16'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    push_tick(16'd0, 16'hFF9D, 32'sd0, 32'sd0, 32'sd0, 1'b1);         // just inside deadband
    push_tick(16'd0, 16'hFFFF, 32'sd0, 32'sd0, 32'sd0, 1'b1);         // on the deadband edge
    push_tick(16'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1);
    push_tick(16'd1, 16'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1);
    push_tick(16'h7FFF, 16'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1);         // error saturates high
    push_tick(16'h7FFF, 16'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1);
    push_tick(16'h8000, 16'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1);         // half-turn wraps negative
    push_tick(16'h8000, 16'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1);         // error saturates low
    push_tick(16'd0, 16'h8000, 32'sd0, 32'sd0, 32'sd0, 1'b1);
    push_tick(16'd0, 16'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1);
    push_tick(16'd0, 16'd0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
    push_tick(16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    push_tick(16'd1, 16'hFFFF, 32'sd65536, -32'sd65536, 32'sd0, 1'b1);
    wait_quiet();

    set_cfg('1, '1, '1, '1, '1, '1, '1, '1);
    push_tick(16'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    push_tick(16'h7FFF, 16'd0, 32'sd1, 32'sd0, 32'sd0, 1'b1);
    push_tick(16'h7FFF, 16'd0, 32'sd0, -32'sd1, 32'sd0, 1'b1);
    push_tick(16'h8000, 16'd0, 32'sd0, 32'sd0, 32'sh80000000, 1'b1);
    push_tick(16'h8000, 16'd0, 32'sh80000000, 32'sh7FFFFFFF, 32'sd0, 1'b1);
    push_tick(16'h8000, 16'hFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1);
    wait_quiet();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int i = 0; i < 8; i++) cfg_write(reg_idx_t'(i), rand_cfg());
      n_settings++;
      if (ph == RANDOM_PHASES - 1) idle_on = 1'b0;
      if (ph == 1) begin
        @(posedge clk);
        m_long_hold = 250;
      end
      for (int i = 0; i < TICKS_PER_PHASE; i++) push_random_tick();
      wait_quiet();
    end

    $display("Covered %0d servo ticks (%0d disabled) over %0d register settings, %0d writes.",
             n_ticks, n_disabled, n_settings, n_writes);
    $display("Compared %0d results field by field; %0d field mismatches.", n_results,
             mismatches);
    if (mismatches == 0 && servo_out_q.size() == 0) begin
      $display("cascaded_position_velocity_pi verification clean");
    end else begin
      $display("cascaded_position_velocity_pi verification failed");
    end
    $finish;
  end

endmodule
